>>> rtl/tlmts_pkg.sv
// ---------------------------------------------------------------------------
// tlmts_pkg: shared constants and types
// Defaults, list selector codes, queue sizing and the result record.
// ---------------------------------------------------------------------------
package tlmts_pkg;

  localparam int LIST_DEPTH_DEF = 256;
  localparam int TIME_BITS_DEF  = 16;
  localparam int FIELD_BITS     = 16;
  localparam int SPAN_BITS      = 16;
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 16'd20000;

  // Two banks per list: one being loaded, one being searched.
  localparam int NUM_BANKS   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_THIRD  = 2'd2;
  localparam logic [1:0] SEL_NONE   = 2'd3;

  typedef struct packed {
    logic [SPAN_BITS-1:0] min_span;
    logic                 overflow;
  } result_t;

endpackage

>>> rtl/three_list_min_time_span.sv
// ---------------------------------------------------------------------------
// three_list_min_time_span: smallest span covering three sorted lists
// Loads three timestamp lists and reports the smallest max-minus-min window
// that holds one entry of each list.
// ---------------------------------------------------------------------------
// Each accepted item writes its value into the list that
// req_type selects (req_type 3 only counts for last_item). An item with
// last_item closes the set: the set is queued for the search engine and
// loading of the next set may start at once into the other bank of list
// storage. The search primes the read ports and then walks one merge step per
// cycle (at most the sum of the three list lengths); each list memory has a
// single read port. A set with an empty list skips the walk and reports
// empty_span_value. full rises while both banks hold sets whose results are
// not yet posted, so two sets can be in flight. The result's overflow is set
// when a value of its set was dropped on a full list (masked if job_full).
// ---------------------------------------------------------------------------
module three_list_min_time_span #(
  parameter int LIST_DEPTH = tlmts_pkg::LIST_DEPTH_DEF,
  parameter int TIME_BITS  = tlmts_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        req_type,
  input  logic [tlmts_pkg::FIELD_BITS-1:0]  time_value,
  input  logic                              last_item,
  output logic                              empty,
  input  logic                              pop,
  output logic [tlmts_pkg::SPAN_BITS-1:0]   min_span,
  output logic                              overflow,
  input  logic                              empty_span_we,
  input  logic [tlmts_pkg::SPAN_BITS-1:0]   empty_span_value
);

  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int AW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int RAM_DEPTH = tlmts_pkg::NUM_BANKS * (2 ** AW);
  localparam int JOB_W     = 3 * CW + 2;
  localparam int RES_W     = $bits(tlmts_pkg::result_t);

  logic [tlmts_pkg::SPAN_BITS-1:0] span_limit;

  logic [2:0]                  wr_en;
  logic [AW:0]                 wr_addr;
  logic [TIME_BITS-1:0]        wr_data;
  logic [2:0][AW:0]            rd_addr;
  logic [2:0][TIME_BITS-1:0]   rd_data;

  logic                        job_push;
  logic [2:0][CW-1:0]          front_counts;
  logic                        front_overflow;
  logic                        front_bank;
  logic [JOB_W-1:0]            job_wdata;
  logic [JOB_W-1:0]            job_rdata;
  logic                        job_full;
  logic                        job_empty;
  logic                        job_pop;
  logic [tlmts_pkg::QUEUE_AW:0] job_count;
  logic                        busy;
  logic                        hold;

  logic                        res_push;
  logic                        res_full;
  tlmts_pkg::result_t          res_in;
  logic [RES_W-1:0]            res_rdata;
  tlmts_pkg::result_t          res_out;
  logic [tlmts_pkg::QUEUE_AW:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit <= tlmts_pkg::SPAN_RESET;
    end else if (empty_span_we) begin
      span_limit <= empty_span_value;
    end
  end

  // Both banks taken: one set queued or searching per bank.
  assign hold = ((tlmts_pkg::QUEUE_AW + 2)'(job_count) +
                 (tlmts_pkg::QUEUE_AW + 2)'(busy)) >=
                (tlmts_pkg::QUEUE_AW + 2)'(tlmts_pkg::NUM_BANKS);

  tlmts_front #(
    .LIST_DEPTH (LIST_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .time_value   (time_value),
    .last_item    (last_item),
    .hold         (hold),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job_counts   (front_counts),
    .job_overflow (front_overflow),
    .job_bank     (front_bank)
  );

  for (genvar g = 0; g < 3; g++) begin : g_list
    tlmts_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en[g]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr[g]),
      .rdata (rd_data[g])
    );
  end

  assign job_wdata = {front_counts, front_overflow, front_bank};

  tlmts_fifo #(
    .WIDTH (JOB_W)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty),
    .count (job_count)
  );

  tlmts_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (job_empty),
    .job_counts   (job_rdata[JOB_W-1:2]),
    .job_overflow (job_rdata[1]),
    .job_bank     (job_rdata[0]),
    .job_pop      (job_pop),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .span_limit   (span_limit),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_in),
    .busy         (busy)
  );

  tlmts_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign res_out  = tlmts_pkg::result_t'(res_rdata);
  assign min_span = res_out.min_span;
  assign overflow = res_out.overflow & ~job_full & (res_count != '0);

endmodule

>>> rtl/tlmts_ram.sv
// ---------------------------------------------------------------------------
// tlmts_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tlmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tlmts_fifo.sv
// ---------------------------------------------------------------------------
// tlmts_fifo: small register queue
// Two-entry first-in first-out queue with occupancy count.
// ---------------------------------------------------------------------------
module tlmts_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [tlmts_pkg::QUEUE_AW:0] count
);

  logic [WIDTH-1:0]                  entries [tlmts_pkg::QUEUE_DEPTH];
  logic [tlmts_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [tlmts_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count == (tlmts_pkg::QUEUE_AW + 1)'(tlmts_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/tlmts_front.sv
// ---------------------------------------------------------------------------
// tlmts_front: list loader
// Appends values to the selected list bank, counts entries, flags drops,
// and hands a finished set to the search queue.
// ---------------------------------------------------------------------------
module tlmts_front #(
  parameter int LIST_DEPTH = tlmts_pkg::LIST_DEPTH_DEF,
  parameter int TIME_BITS  = tlmts_pkg::TIME_BITS_DEF,
  localparam int CW   = $clog2(LIST_DEPTH + 1),
  localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int EXTW = (TIME_BITS > tlmts_pkg::FIELD_BITS) ? TIME_BITS
                                                            : tlmts_pkg::FIELD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          req_type,
  input  logic [tlmts_pkg::FIELD_BITS-1:0]    time_value,
  input  logic                                last_item,
  input  logic                                hold,
  output logic [2:0]                          wr_en,
  output logic [AW:0]                         wr_addr,
  output logic [TIME_BITS-1:0]                wr_data,
  output logic                                job_push,
  output logic [2:0][CW-1:0]                  job_counts,
  output logic                                job_overflow,
  output logic                                job_bank
);

  logic [2:0][CW-1:0] counts;
  logic [2:0][CW-1:0] counts_next;
  logic               ovf;
  logic               ovf_next;
  logic               bank;
  logic               accept;
  logic [CW-1:0]      cur_count;
  logic [EXTW-1:0]    value_ext;

  assign full      = hold;
  assign accept    = push & ~hold;
  assign value_ext = EXTW'(time_value);
  assign wr_data   = value_ext[TIME_BITS-1:0];

  always_comb begin
    case (req_type)
      tlmts_pkg::SEL_FIRST:  cur_count = counts[0];
      tlmts_pkg::SEL_SECOND: cur_count = counts[1];
      tlmts_pkg::SEL_THIRD:  cur_count = counts[2];
      default:               cur_count = '0;
    endcase
  end

  assign wr_addr = {bank, cur_count[AW-1:0]};

  always_comb begin
    counts_next = counts;
    ovf_next    = ovf;
    wr_en       = '0;
    if (accept && req_type != tlmts_pkg::SEL_NONE) begin
      if (cur_count < CW'(LIST_DEPTH)) begin
        case (req_type)
          tlmts_pkg::SEL_FIRST: begin
            wr_en[0]       = 1'b1;
            counts_next[0] = cur_count + 1'b1;
          end
          tlmts_pkg::SEL_SECOND: begin
            wr_en[1]       = 1'b1;
            counts_next[1] = cur_count + 1'b1;
          end
          default: begin
            wr_en[2]       = 1'b1;
            counts_next[2] = cur_count + 1'b1;
          end
        endcase
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  assign job_push     = accept & last_item;
  assign job_counts   = counts_next;
  assign job_overflow = ovf_next;
  assign job_bank     = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      ovf    <= 1'b0;
      bank   <= 1'b0;
    end else if (job_push) begin
      counts <= '0;
      ovf    <= 1'b0;
      bank   <= ~bank;
    end else begin
      counts <= counts_next;
      ovf    <= ovf_next;
    end
  end

endmodule

>>> rtl/tlmts_back.sv
// ---------------------------------------------------------------------------
// tlmts_back: span search
// Walks the three lists of one bank, one merge step per cycle, keeping the
// smallest max-minus-min span, then posts the result.
// ---------------------------------------------------------------------------
module tlmts_back #(
  parameter int LIST_DEPTH = tlmts_pkg::LIST_DEPTH_DEF,
  parameter int TIME_BITS  = tlmts_pkg::TIME_BITS_DEF,
  localparam int CW   = $clog2(LIST_DEPTH + 1),
  localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int EXTW = (TIME_BITS > tlmts_pkg::SPAN_BITS) ? TIME_BITS
                                                           : tlmts_pkg::SPAN_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               job_empty,
  input  logic [2:0][CW-1:0]                 job_counts,
  input  logic                               job_overflow,
  input  logic                               job_bank,
  output logic                               job_pop,
  output logic [2:0][AW:0]                   rd_addr,
  input  logic [2:0][TIME_BITS-1:0]          rd_data,
  input  logic [tlmts_pkg::SPAN_BITS-1:0]    span_limit,
  input  logic                               res_full,
  output logic                               res_push,
  output tlmts_pkg::result_t                 res,
  output logic                               busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                    state;
  logic [2:0][CW-1:0]            ptr;
  logic [2:0][CW-1:0]            ptr_step;
  logic [2:0][CW-1:0]            ptr_next;
  logic [2:0][CW-1:0]            lim;
  logic                          bank;
  logic                          ovf;
  logic [tlmts_pkg::SPAN_BITS-1:0] best;
  logic [tlmts_pkg::SPAN_BITS-1:0] best_step;
  logic [TIME_BITS-1:0]          lo;
  logic [TIME_BITS-1:0]          hi;
  logic [EXTW-1:0]               d_ext;
  logic [1:0]                    adv;
  logic                          walk_done;
  logic                          any_empty;

  // Min/max of the three heads and the span.
  always_comb begin
    lo = rd_data[0];
    hi = rd_data[0];
    if (rd_data[1] < lo) lo = rd_data[1];
    if (rd_data[2] < lo) lo = rd_data[2];
    if (rd_data[1] > hi) hi = rd_data[1];
    if (rd_data[2] > hi) hi = rd_data[2];
  end

  assign d_ext     = EXTW'(hi - lo);
  assign best_step = (d_ext < EXTW'(best)) ? d_ext[tlmts_pkg::SPAN_BITS-1:0] : best;

  // Advance the first list whose head is the minimum.
  always_comb begin
    if (lo == rd_data[0]) begin
      adv = 2'd0;
    end else if (lo == rd_data[1]) begin
      adv = 2'd1;
    end else begin
      adv = 2'd2;
    end
  end

  always_comb begin
    ptr_step  = ptr;
    walk_done = (best_step == '0);
    for (int k = 0; k < 3; k++) begin
      if (adv == 2'(k)) begin
        ptr_step[k] = ptr[k] + 1'b1;
        if (ptr[k] + 1'b1 == lim[k]) walk_done = 1'b1;
      end
    end
  end

  assign ptr_next = (state == ST_WALK) ? ptr_step : ptr;

  // Read address looks one step ahead so data lines up with ptr.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_addr[k] = {bank, ptr_next[k][AW-1:0]};
    end
  end

  assign any_empty    = (job_counts[0] == '0) | (job_counts[1] == '0) |
                        (job_counts[2] == '0);
  assign job_pop      = (state == ST_IDLE) & ~job_empty;
  assign res_push     = (state == ST_EMIT) & ~res_full;
  assign busy         = (state != ST_IDLE);
  assign res.min_span = best;
  assign res.overflow = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= any_empty ? ST_EMIT : ST_PRIME;
          end
        end
        ST_PRIME: state <= ST_WALK;
        ST_WALK: begin
          if (walk_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !job_empty) begin
      lim  <= job_counts;
      bank <= job_bank;
      ovf  <= job_overflow;
      ptr  <= '0;
      best <= span_limit;
    end else if (state == ST_WALK) begin
      ptr  <= ptr_step;
      best <= best_step;
    end
  end

endmodule

>>> tb/three_list_min_time_span_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_list_min_time_span_test: self-checking bench for the span search
// Loads sets of three timestamp lists through the push side and checks each
// reported span and overflow flag against a behavioral model kept in the
// bench. Both sides stall in random bursts; the cap register is retuned
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module three_list_min_time_span_test;

  typedef struct packed {
    logic [1:0]                       sel;
    logic [tlmts_pkg::FIELD_BITS-1:0] value;
    logic                             last;
  } load_item_t;

  logic                            clk              = 1'b0;
  logic                            rst              = 1'b1;
  logic                            push             = 1'b0;
  logic                            full;
  logic [1:0]                      req_type         = tlmts_pkg::SEL_FIRST;
  logic [tlmts_pkg::FIELD_BITS-1:0] time_value      = '0;
  logic                            last_item        = 1'b0;
  logic                            empty;
  logic                            pop              = 1'b0;
  logic [tlmts_pkg::SPAN_BITS-1:0] min_span;
  logic                            overflow;
  logic                            empty_span_we    = 1'b0;
  logic [tlmts_pkg::SPAN_BITS-1:0] empty_span_value = '0;

  three_list_min_time_span dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .req_type         (req_type),
    .time_value       (time_value),
    .last_item        (last_item),
    .empty            (empty),
    .pop              (pop),
    .min_span         (min_span),
    .overflow         (overflow),
    .empty_span_we    (empty_span_we),
    .empty_span_value (empty_span_value)
  );

  always #5 clk = ~clk;

  // stimulus and expectations
  load_item_t           load_queue[$];
  tlmts_pkg::result_t   expected_spans[$];
  int                   n_issued    = 0;
  int                   n_taken     = 0;
  int                   mismatches  = 0;
  bit                   calm        = 1'b0;
  bit                   item_taken  = 1'b0;
  int                   send_gap    = 0;
  int                   pop_gap     = 0;
  load_item_t           next_item;

  // bench copy of the list storage and the cap register
  logic [tlmts_pkg::FIELD_BITS-1:0] list_mem [3][tlmts_pkg::LIST_DEPTH_DEF];
  int                               list_len [3];
  bit                               list_ovf  = 1'b0;
  logic [tlmts_pkg::SPAN_BITS-1:0]  span_cap  = tlmts_pkg::SPAN_RESET;

  // Appends one value and, on the closing item, runs the three-way merge.
  task automatic apply_to_lists(input logic [1:0] sel,
                                input logic [tlmts_pkg::FIELD_BITS-1:0] value,
                                input logic last);
    int ia, ib, ic;
    logic [tlmts_pkg::SPAN_BITS-1:0] x, y, z, lo, hi, d, best;
    tlmts_pkg::result_t r;
    if (sel != tlmts_pkg::SEL_NONE) begin
      if (list_len[sel] < tlmts_pkg::LIST_DEPTH_DEF) begin
        list_mem[sel][list_len[sel]] = value;
        list_len[sel] = list_len[sel] + 1;
      end else begin
        list_ovf = 1'b1;
      end
    end
    if (last) begin
      best = span_cap;
      ia = 0;
      ib = 0;
      ic = 0;
      while (ia < list_len[0] && ib < list_len[1] && ic < list_len[2]) begin
        x = list_mem[0][ia];
        y = list_mem[1][ib];
        z = list_mem[2][ic];
        lo = x;
        hi = x;
        if (y < lo) lo = y;
        if (z < lo) lo = z;
        if (y > hi) hi = y;
        if (z > hi) hi = z;
        d = hi - lo;
        if (d < best) best = d;
        if (best == 0) break;
        // ties go to the lowest-numbered list
        if (lo == x) ia++;
        else if (lo == y) ib++;
        else ic++;
      end
      r.min_span = best;
      r.overflow = list_ovf;
      expected_spans.push_back(r);
      list_len[0] = 0;
      list_len[1] = 0;
      list_len[2] = 0;
      list_ovf = 1'b0;
    end
  endtask

  // accept side: sample on rising edge
  always @(posedge clk) begin
    item_taken = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        item_taken = 1'b1;
        n_taken++;
        apply_to_lists(req_type, time_value, last_item);
      end
      if (pop && !empty) begin
        if (expected_spans.size() == 0) begin
          $error("unexpected result transaction: min_span=%0d overflow=%0b", min_span, overflow);
          mismatches++;
        end else begin
          if (min_span !== expected_spans[0].min_span) begin
            $error("min_span: expected %0d, actual %0d", expected_spans[0].min_span, min_span);
            mismatches++;
          end
          if (overflow !== expected_spans[0].overflow) begin
            $error("overflow: expected %0b, actual %0b", expected_spans[0].overflow, overflow);
            mismatches++;
          end
          void'(expected_spans.pop_front());
        end
      end
    end
  end

  // load driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (load_queue.size() != 0) begin
        next_item = load_queue.pop_front();
        push       <= 1'b1;
        req_type   <= next_item.sel;
        time_value <= next_item.value;
        last_item  <= next_item.last;
        if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result drain with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_gap = $urandom_range(0, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic add_item(input logic [1:0] sel,
                          input logic [tlmts_pkg::FIELD_BITS-1:0] value,
                          input logic last);
    load_item_t it;
    it.sel   = sel;
    it.value = value;
    it.last  = last;
    load_queue.push_back(it);
    n_issued++;
  endtask

  // Three non-decreasing lists, interleaved at random; optionally closed by
  // an ignored selector-three item.
  task automatic add_sorted_set(input int n0, input int n1, input int n2, input int step_max,
                                input bit none_tail);
    int left [3];
    int cur [3];
    bit started [3];
    int base, s, total, k;
    left[0] = n0;
    left[1] = n1;
    left[2] = n2;
    total = n0 + n1 + n2;
    case ($urandom_range(0, 7))
      0: base = 0;
      1: base = 65535 - $urandom_range(0, 64);
      default: base = $urandom_range(0, 65535);
    endcase
    for (k = 0; k < 3; k++) started[k] = 1'b0;
    for (k = 0; k < total; k++) begin
      do s = $urandom_range(0, 2); while (left[s] == 0);
      if (!started[s]) begin
        cur[s] = base + $urandom_range(0, 2 * step_max);
        if (cur[s] > 65535) cur[s] = 65535;
        started[s] = 1'b1;
      end
      add_item(s[1:0], cur[s][tlmts_pkg::FIELD_BITS-1:0], !none_tail && k == total - 1);
      cur[s] = cur[s] + $urandom_range(0, step_max);
      if (cur[s] > 65535) cur[s] = 65535;
      left[s]--;
    end
    if (none_tail || total == 0) begin
      add_item(tlmts_pkg::SEL_NONE, tlmts_pkg::FIELD_BITS'($urandom_range(0, 65535)), 1'b1);
    end
  endtask

  task automatic run_sets(input int target);
    int start, k, len, step_max;
    start = n_issued;
    while (n_issued - start < target) begin
      step_max = $urandom_range(0, 1 << $urandom_range(0, 12));
      case ($urandom_range(0, 9))
        7: begin
          // unsorted noise, any selector
          len = $urandom_range(1, 10);
          for (k = 0; k < len; k++)
            add_item(2'($urandom_range(0, 3)),
                     tlmts_pkg::FIELD_BITS'($urandom_range(0, 65535)), k == len - 1);
        end
        8: add_sorted_set($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                          step_max, 1'b1);
        9: begin
          // one list left empty
          case ($urandom_range(0, 2))
            0: add_sorted_set(0, $urandom_range(1, 5), $urandom_range(1, 5), step_max, 1'b0);
            1: add_sorted_set($urandom_range(1, 5), 0, $urandom_range(1, 5), step_max, 1'b0);
            default: add_sorted_set($urandom_range(1, 5), $urandom_range(1, 5), 0, step_max,
                                    1'b0);
          endcase
        end
        default: add_sorted_set($urandom_range(1, 8), $urandom_range(1, 8),
                                $urandom_range(1, 8), step_max, 1'b0);
      endcase
    end
  endtask

  task automatic wait_quiet();
    while (n_taken != n_issued || expected_spans.size() != 0) @(negedge clk);
  endtask

  task automatic retune_empty_span(input logic [tlmts_pkg::SPAN_BITS-1:0] v);
    wait_quiet();
    repeat (16) @(negedge clk);
    empty_span_we    = 1'b1;
    empty_span_value = v;
    @(negedge clk);
    empty_span_we    = 1'b0;
    span_cap         = v;
  endtask

  initial begin
    list_len[0] = 0;
    list_len[1] = 0;
    list_len[2] = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: zero span stops at once
    add_item(tlmts_pkg::SEL_FIRST, 16'd0, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'd0, 1'b0);
    add_item(tlmts_pkg::SEL_THIRD, 16'd0, 1'b1);
    // full-range span, clipped by the cap
    add_item(tlmts_pkg::SEL_FIRST, 16'hFFFF, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'h0000, 1'b0);
    add_item(tlmts_pkg::SEL_THIRD, 16'hFFFF, 1'b1);
    // third list empty, closed by selector three
    add_item(tlmts_pkg::SEL_FIRST, 16'h0000, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'hFFFF, 1'b0);
    add_item(tlmts_pkg::SEL_NONE, 16'h5555, 1'b1);
    // nothing loaded at all
    add_item(tlmts_pkg::SEL_NONE, 16'hAAAA, 1'b1);
    // unsorted lists
    add_item(tlmts_pkg::SEL_FIRST, 16'd50, 1'b0);
    add_item(tlmts_pkg::SEL_FIRST, 16'd10, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'd40, 1'b0);
    add_item(tlmts_pkg::SEL_THIRD, 16'd30, 1'b0);
    add_item(tlmts_pkg::SEL_THIRD, 16'd5, 1'b1);
    // ordinary sorted walk with ties
    add_item(tlmts_pkg::SEL_THIRD, 16'd90, 1'b0);
    add_item(tlmts_pkg::SEL_FIRST, 16'd100, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'd100, 1'b0);
    add_item(tlmts_pkg::SEL_SECOND, 16'd130, 1'b0);
    add_item(tlmts_pkg::SEL_THIRD, 16'd115, 1'b0);
    add_item(tlmts_pkg::SEL_FIRST, 16'd120, 1'b1);

    retune_empty_span(16'hFFFF);
    // every list at full depth, then one list past capacity
    add_sorted_set(tlmts_pkg::LIST_DEPTH_DEF, tlmts_pkg::LIST_DEPTH_DEF,
                   tlmts_pkg::LIST_DEPTH_DEF, 4, 1'b0);
    case ($urandom_range(0, 2))
      0: add_sorted_set(tlmts_pkg::LIST_DEPTH_DEF + 2, 1, 1, 50, 1'b0);
      1: add_sorted_set(1, tlmts_pkg::LIST_DEPTH_DEF + 2, 1, 50, 1'b0);
      default: add_sorted_set(1, 1, tlmts_pkg::LIST_DEPTH_DEF + 2, 50, 1'b0);
    endcase
    run_sets(130);

    retune_empty_span(16'h0000);
    run_sets(100);

    retune_empty_span(16'h0001);
    run_sets(100);

    retune_empty_span(tlmts_pkg::SPAN_BITS'($urandom_range(0, 65535)));
    run_sets(150);

    retune_empty_span(tlmts_pkg::SPAN_RESET);
    calm = 1'b1;
    run_sets(150);

    wait_quiet();
    repeat (800) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> three_list_min_time_span.f
rtl/tlmts_pkg.sv
rtl/tlmts_ram.sv
rtl/tlmts_fifo.sv
rtl/tlmts_front.sv
rtl/tlmts_back.sv
rtl/three_list_min_time_span.sv
tb/three_list_min_time_span_test.sv
